/* rtl/dra_pkg.sv */
// shared types and constants of the 64-bit register data-processing alu
`default_nettype none

package dra_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned HALF_W    = 32;
  localparam int unsigned REG_IDX_W = 5;

  // register 31 reads as zero and discards writes
  localparam logic [REG_IDX_W-1:0] ZERO_REG = 5'd31;

  typedef enum logic [3:0] {
    MODE_ADD  = 4'd0,
    MODE_SUB  = 4'd1,
    MODE_ADDS = 4'd2,
    MODE_SUBS = 4'd3,
    MODE_AND  = 4'd4,
    MODE_BIC  = 4'd5,
    MODE_ORR  = 4'd6,
    MODE_ORN  = 4'd7,
    MODE_EOR  = 4'd8,
    MODE_EON  = 4'd9,
    MODE_ANDS = 4'd10,
    MODE_BICS = 4'd11,
    MODE_MADD = 4'd12,
    MODE_MSUB = 4'd13
  } mode_e;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_e;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } nzcv_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              illegal;
    nzcv_t             flags;
  } alu_res_t;

endpackage

`default_nettype wire

/* rtl/dra_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module dra_ram #(
  parameter  int unsigned WIDTH = 64,
  parameter  int unsigned DEPTH = 31,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/dra_alu.sv */
// shifter, add/sub, logic and multiply-add datapath with nzcv generation
`default_nettype none

module dra_alu
  import dra_pkg::*;
(
  input  wire logic [3:0]        mode_i,
  input  wire logic [1:0]        shift_type_i,
  input  wire logic [5:0]        shift_dist_i,
  input  wire logic [WORD_W-1:0] op_a_i,
  input  wire logic [WORD_W-1:0] op_m_i,
  input  wire logic [WORD_W-1:0] op_acc_i,
  input  wire nzcv_t             flags_i,
  output alu_res_t               res_o
);

  logic [WORD_W-1:0]   shifted_w;
  logic [2*WORD_W-1:0] rot_w;
  logic [WORD_W:0]     add_w;
  logic [WORD_W:0]     sub_w;
  logic [WORD_W-1:0]   pp_ll_w;
  logic [HALF_W-1:0]   pp_lh_w;
  logic [HALF_W-1:0]   pp_hl_w;
  logic [HALF_W-1:0]   cross_w;
  logic [WORD_W-1:0]   prod_w;
  logic                is_ror;

  function automatic nzcv_t nz_flags(input logic [WORD_W-1:0] r, input logic c,
                                     input logic v);
    nzcv_t f;
    f.n = r[WORD_W-1];
    f.z = (r == '0);
    f.c = c;
    f.v = v;
    return f;
  endfunction

  assign rot_w = {op_m_i, op_m_i} >> shift_dist_i;

  always_comb begin
    case (shift_e'(shift_type_i))
      SH_LSL:  shifted_w = op_m_i << shift_dist_i;
      SH_LSR:  shifted_w = op_m_i >> shift_dist_i;
      SH_ASR:  shifted_w = WORD_W'($signed(op_m_i) >>> shift_dist_i);
      SH_ROR:  shifted_w = rot_w[WORD_W-1:0];
      default: shifted_w = op_m_i;
    endcase
  end

  assign add_w = {1'b0, op_a_i} + {1'b0, shifted_w};
  assign sub_w = {1'b0, op_a_i} + {1'b0, ~shifted_w} + (WORD_W+1)'(1);

  // low 64 bits of the product from three 32x32 partial products
  assign pp_ll_w = {{HALF_W{1'b0}}, op_a_i[HALF_W-1:0]} *
                   {{HALF_W{1'b0}}, op_m_i[HALF_W-1:0]};
  assign pp_lh_w = op_a_i[HALF_W-1:0] * op_m_i[WORD_W-1:HALF_W];
  assign pp_hl_w = op_a_i[WORD_W-1:HALF_W] * op_m_i[HALF_W-1:0];
  assign cross_w = pp_lh_w + pp_hl_w;
  assign prod_w  = pp_ll_w + {cross_w, {HALF_W{1'b0}}};

  assign is_ror = (shift_e'(shift_type_i) == SH_ROR);

  always_comb begin
    res_o.value   = '0;
    res_o.illegal = 1'b0;
    res_o.flags   = flags_i;
    unique case (mode_e'(mode_i))
      MODE_ADD: begin
        if (is_ror) res_o.illegal = 1'b1;
        else        res_o.value   = add_w[WORD_W-1:0];
      end
      MODE_SUB: begin
        if (is_ror) res_o.illegal = 1'b1;
        else        res_o.value   = sub_w[WORD_W-1:0];
      end
      MODE_ADDS: begin
        if (is_ror) begin
          res_o.illegal = 1'b1;
        end else begin
          res_o.value = add_w[WORD_W-1:0];
          res_o.flags = nz_flags(add_w[WORD_W-1:0], add_w[WORD_W],
                                 ~(op_a_i[WORD_W-1] ^ shifted_w[WORD_W-1]) &
                                 (op_a_i[WORD_W-1] ^ add_w[WORD_W-1]));
        end
      end
      MODE_SUBS: begin
        if (is_ror) begin
          res_o.illegal = 1'b1;
        end else begin
          res_o.value = sub_w[WORD_W-1:0];
          res_o.flags = nz_flags(sub_w[WORD_W-1:0], sub_w[WORD_W],
                                 (op_a_i[WORD_W-1] ^ shifted_w[WORD_W-1]) &
                                 (op_a_i[WORD_W-1] ^ sub_w[WORD_W-1]));
        end
      end
      MODE_AND: res_o.value = op_a_i & shifted_w;
      MODE_BIC: res_o.value = op_a_i & ~shifted_w;
      MODE_ORR: res_o.value = op_a_i | shifted_w;
      MODE_ORN: res_o.value = op_a_i | ~shifted_w;
      MODE_EOR: res_o.value = op_a_i ^ shifted_w;
      MODE_EON: res_o.value = op_a_i ^ ~shifted_w;
      MODE_ANDS: begin
        res_o.value = op_a_i & shifted_w;
        res_o.flags = nz_flags(op_a_i & shifted_w, 1'b0, 1'b0);
      end
      MODE_BICS: begin
        res_o.value = op_a_i & ~shifted_w;
        res_o.flags = nz_flags(op_a_i & ~shifted_w, 1'b0, 1'b0);
      end
      MODE_MADD: res_o.value = op_acc_i + prod_w;
      MODE_MSUB: res_o.value = op_acc_i - prod_w;
      default:   res_o.illegal = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/dp_register_alu_64.sv */
// top level: operand fetch, execute stage, register file, flags and result register
`default_nettype none

// Executes one pre-decoded 64-bit data-processing operation per item (add/sub
// with lsl/lsr/asr second operand, logic ops with any shift, madd/msub) against
// a register file of REG_COUNT entries and the nzcv flags. One item is taken in
// every cycle while the output is not stalled; the register file read and the
// execute stage capture an item when it is accepted, then one pass through the
// shifter/adder/multiplier goes into the result register, which makes the
// result valid. A result that depends on the item just before it is forwarded,
// so back-to-back dependent items run at full rate. The register file is three
// copies of a one-write, one-read ram (one per source operand) with per-entry
// valid bits cleared at reset, so no clearing pass is needed. Register 31 and
// indexes at or above REG_COUNT read as zero and are never written. A ror shift
// on an add/sub form or an unused mode gives illegal, a zero value, written_reg
// 31 and leaves registers and flags untouched.
module dp_register_alu_64
  import dra_pkg::*;
#(
  parameter int unsigned REG_COUNT = 31
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [3:0]           mode_i,
  input  wire logic [1:0]           shift_type_i,
  input  wire logic [5:0]           shift_dist_i,
  input  wire logic [REG_IDX_W-1:0] dest_reg_i,
  input  wire logic [REG_IDX_W-1:0] first_reg_i,
  input  wire logic [REG_IDX_W-1:0] second_reg_i,
  input  wire logic [REG_IDX_W-1:0] accum_reg_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [WORD_W-1:0]         written_value_o,
  output logic [REG_IDX_W-1:0]      written_reg_o,
  output logic                      flag_n_o,
  output logic                      flag_z_o,
  output logic                      flag_c_o,
  output logic                      flag_v_o,
  output logic                      illegal_o
);

  localparam int unsigned AW = $clog2(REG_COUNT);
  localparam logic [REG_IDX_W-1:0] REG_LIMIT = REG_IDX_W'(REG_COUNT);

  logic in_fire;
  logic s1_adv;

  // execute stage
  logic                 s1_vld_q;
  logic [3:0]           s1_mode_q;
  logic [1:0]           s1_type_q;
  logic [5:0]           s1_amt_q;
  logic [REG_IDX_W-1:0] s1_dest_q;
  logic [REG_IDX_W-1:0] s1_rn_q;
  logic [REG_IDX_W-1:0] s1_rm_q;
  logic [REG_IDX_W-1:0] s1_ra_q;
  logic [2:0]           s1_ok_q;

  // register file state
  logic [REG_COUNT-1:0] rf_vld_q;
  logic                 last_vld_q;
  logic [REG_IDX_W-1:0] last_idx_q;
  logic [WORD_W-1:0]    last_data_q;
  nzcv_t                flags_q;

  // result register
  logic                 out_vld_q;
  logic [WORD_W-1:0]    out_value_q;
  logic [REG_IDX_W-1:0] out_reg_q;
  nzcv_t                out_flags_q;
  logic                 out_illegal_q;

  logic [WORD_W-1:0] rd_n;
  logic [WORD_W-1:0] rd_m;
  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] op_a;
  logic [WORD_W-1:0] op_m;
  logic [WORD_W-1:0] op_acc;
  logic              rf_we;
  alu_res_t          alu_res;

  function automatic logic idx_live(input logic [REG_IDX_W-1:0] idx);
    return (idx != ZERO_REG) && (idx < REG_LIMIT);
  endfunction

  assign s1_adv     = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  dra_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_n (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s1_dest_q[AW-1:0]),
    .wdata_i (alu_res.value),
    .re_i    (in_fire),
    .raddr_i (first_reg_i[AW-1:0]),
    .rdata_o (rd_n)
  );

  dra_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_m (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s1_dest_q[AW-1:0]),
    .wdata_i (alu_res.value),
    .re_i    (in_fire),
    .raddr_i (second_reg_i[AW-1:0]),
    .rdata_o (rd_m)
  );

  dra_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s1_dest_q[AW-1:0]),
    .wdata_i (alu_res.value),
    .re_i    (in_fire),
    .raddr_i (accum_reg_i[AW-1:0]),
    .rdata_o (rd_a)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_fire) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  // a source is readable if live and written since reset; a write landing at
  // the same edge as the read is covered by forwarding below
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mode_q  <= mode_i;
      s1_type_q  <= shift_type_i;
      s1_amt_q   <= shift_dist_i;
      s1_dest_q  <= dest_reg_i;
      s1_rn_q    <= first_reg_i;
      s1_rm_q    <= second_reg_i;
      s1_ra_q    <= accum_reg_i;
      s1_ok_q[0] <= idx_live(first_reg_i) && rf_vld_q[first_reg_i[AW-1:0]];
      s1_ok_q[1] <= idx_live(second_reg_i) && rf_vld_q[second_reg_i[AW-1:0]];
      s1_ok_q[2] <= idx_live(accum_reg_i) && rf_vld_q[accum_reg_i[AW-1:0]];
    end
  end

  // the most recent write is always the current value of its register
  assign op_a   = (last_vld_q && s1_rn_q == last_idx_q) ? last_data_q :
                  (s1_ok_q[0] ? rd_n : '0);
  assign op_m   = (last_vld_q && s1_rm_q == last_idx_q) ? last_data_q :
                  (s1_ok_q[1] ? rd_m : '0);
  assign op_acc = (last_vld_q && s1_ra_q == last_idx_q) ? last_data_q :
                  (s1_ok_q[2] ? rd_a : '0);

  dra_alu u_alu (
    .mode_i       (s1_mode_q),
    .shift_type_i (s1_type_q),
    .shift_dist_i (s1_amt_q),
    .op_a_i       (op_a),
    .op_m_i       (op_m),
    .op_acc_i     (op_acc),
    .flags_i      (flags_q),
    .res_o        (alu_res)
  );

  assign rf_we = s1_adv && !alu_res.illegal && idx_live(s1_dest_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q   <= '0;
      last_vld_q <= 1'b0;
      last_idx_q <= '0;
      flags_q    <= '0;
    end else begin
      if (rf_we) begin
        rf_vld_q[s1_dest_q[AW-1:0]] <= 1'b1;
        last_vld_q                  <= 1'b1;
        last_idx_q                  <= s1_dest_q;
      end
      if (s1_adv) begin
        flags_q <= alu_res.flags;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      last_data_q <= alu_res.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_value_q   <= alu_res.value;
      out_reg_q     <= alu_res.illegal ? ZERO_REG : s1_dest_q;
      out_flags_q   <= alu_res.flags;
      out_illegal_q <= alu_res.illegal;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign written_value_o = out_value_q;
  assign written_reg_o   = out_reg_q;
  assign flag_n_o        = out_flags_q.n;
  assign flag_z_o        = out_flags_q.z;
  assign flag_c_o        = out_flags_q.c;
  assign flag_v_o        = out_flags_q.v;
  assign illegal_o       = out_illegal_q;

  a_illegal_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_illegal_q |-> out_reg_q == ZERO_REG && out_value_q == '0)
    else $error("illegal item shows a nonzero value or a live register");

  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s1_vld_q))
    else $error("result appeared without an item in the execute stage");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_vld_q && out_vld_q)
    else $error("input stalled while the pipeline has room");

  a_fwd_entry_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_vld_q |-> rf_vld_q[last_idx_q[AW-1:0]] && idx_live(last_idx_q))
    else $error("forwarded register is not a written live entry");

  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(flags_q))
    else $error("flags changed without an item leaving the execute stage");

endmodule

`default_nettype wire
